[rtl/gmp_basis_generator_defines.svh]
// Assertion macros used by the basis generator RTL.
`ifndef GMP_BASIS_GENERATOR_DEFINES_SVH
`define GMP_BASIS_GENERATOR_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define GMP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define GMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/gmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared widths, register indexes and helper types of the basis generator.
// ----------------------------------------------------------------------------
package gmp_pkg;
    localparam int MAX_ALIGNED_ORDER_DEF = 4;
    localparam int MAX_ALIGNED_DEPTH_DEF = 4;
    localparam int MAX_DELAYED_ORDER_DEF = 4;
    localparam int MAX_ENVELOPE_LAG_DEF  = 3;
    localparam int MAX_DELAYED_DEPTH_DEF = 4;
    localparam int HISTORY_DEPTH_DEF     = 8;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 17;
    localparam int TERM_W   = 20;
    localparam int INDEX_W  = 6;
    localparam int CFG_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int RESULT_LIMIT = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ALIGNED_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGNED_DEPTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAYED_ORDER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_LAG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAYED_DEPTH = 3'd4;

    localparam logic signed [TERM_W-1:0] Q4_MAX = 20'sh7FFFF;
    localparam logic signed [TERM_W-1:0] Q4_MIN = -20'sh80000;

    // Clamped run configuration fed from the configuration registers to the sequencer.
    typedef struct packed {
        logic [3:0] ka;
        logic [3:0] la;
        logic [3:0] kb;
        logic [3:0] mb;
        logic [3:0] lb;
    } run_cfg_t;

    function automatic logic [3:0] clamp_reg(input logic [CFG_W-1:0] v, input int maxv);
        logic [3:0] r;
        begin
            r = {1'b0, v};
            if (r == 4'd0) r = 4'd1;
            if (int'(r) > maxv) r = 4'(maxv);
            return r;
        end
    endfunction
endpackage

[rtl/gmp_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_sample_if / gmp_basis_if
// Valid/ready channels for input samples and basis terms.
// ----------------------------------------------------------------------------
interface gmp_sample_if;
    logic valid;
    logic ready;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    modport source (output valid, sample_re, sample_im, input ready);
    modport sink (input valid, sample_re, sample_im, output ready);
endinterface

interface gmp_basis_if;
    logic valid;
    logic ready;
    logic signed [19:0] basis_re;
    logic signed [19:0] basis_im;
    logic [5:0] basis_index;
    logic last_term;
    modport source (output valid, basis_re, basis_im, basis_index, last_term, input ready);
    modport sink (input valid, basis_re, basis_im, basis_index, last_term, output ready);
endinterface

[rtl/gmp_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gmp_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [16:0] root
);
    logic [33:0] rem_reg, rem_next;
    logic [33:0] res_reg, res_next;
    logic [33:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {2'b00, radicand};
            res_next  = '0;
            bit_next  = 34'h1 << 32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= res_reg + bit_reg)
            begin
                rem_next = rem_reg - (res_reg + bit_reg);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[16:0];
endmodule

[rtl/gmp_basis_generator.sv]
`timescale 1ns / 1ps
// Flow: an accepted sample runs through the square root, then the history shifts one entry
// at a time (read, then write), then the terms are formed one by one; a plain copy term
// skips the scaling step that a scaled term takes. Samples are taken only while idle, so a new
// sample waits until the last term enters the output register; receiver stalls hold the terms.
// Reset: configuration and control registers take defaults, history reads as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
// gmp_basis_generator
// Generalized memory polynomial basis generator, memory-centered sequencer.
// ----------------------------------------------------------------------------
`include "gmp_basis_generator_defines.svh"
module gmp_basis_generator #(
    parameter int MAX_ALIGNED_ORDER = gmp_pkg::MAX_ALIGNED_ORDER_DEF,
    parameter int MAX_ALIGNED_DEPTH = gmp_pkg::MAX_ALIGNED_DEPTH_DEF,
    parameter int MAX_DELAYED_ORDER = gmp_pkg::MAX_DELAYED_ORDER_DEF,
    parameter int MAX_ENVELOPE_LAG  = gmp_pkg::MAX_ENVELOPE_LAG_DEF,
    parameter int MAX_DELAYED_DEPTH = gmp_pkg::MAX_DELAYED_DEPTH_DEF,
    parameter int HISTORY_DEPTH     = gmp_pkg::HISTORY_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    gmp_sample_if.sink  samples,
    gmp_basis_if.source basis,
    input  logic cfg_we,
    input  logic [gmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmp_pkg::CFG_W-1:0] cfg_data
);
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int TW = $clog2(MAX_DELAYED_DEPTH > MAX_ALIGNED_DEPTH ?
                                MAX_DELAYED_DEPTH : MAX_ALIGNED_DEPTH) + 1;
    localparam int TDEPTH = 1 << TW;

    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_SHIFT_RD, S_SHIFT_WR, S_TERM_RD, S_TERM_MUL, S_TERM_WR, S_EMIT
    } state_t;

    // Configuration registers.
    logic [2:0] ka_reg, la_reg, kb_reg, lb_reg;
    logic [1:0] mb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ka_reg <= 3'd2; la_reg <= 3'd2; kb_reg <= 3'd1; mb_reg <= 2'd1; lb_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gmp_pkg::REG_ALIGNED_ORDER: ka_reg <= cfg_data;
                gmp_pkg::REG_ALIGNED_DEPTH: la_reg <= cfg_data;
                gmp_pkg::REG_DELAYED_ORDER: kb_reg <= cfg_data;
                gmp_pkg::REG_ENVELOPE_LAG:  mb_reg <= cfg_data[1:0];
                gmp_pkg::REG_DELAYED_DEPTH: lb_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gmp_pkg::run_cfg_t rc;
    always_comb
    begin
        rc.ka = gmp_pkg::clamp_reg(ka_reg, MAX_ALIGNED_ORDER);
        rc.la = gmp_pkg::clamp_reg(la_reg, MAX_ALIGNED_DEPTH);
        rc.kb = gmp_pkg::clamp_reg(kb_reg, MAX_DELAYED_ORDER);
        rc.mb = gmp_pkg::clamp_reg({1'b0, mb_reg}, MAX_ENVELOPE_LAG);
        rc.lb = gmp_pkg::clamp_reg(lb_reg, MAX_DELAYED_DEPTH);
    end

    // History memory {mag, im, re}, with valid bits so unwritten entries read zero.
    logic [48:0] hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hist_vld_reg;
    logic [48:0] hist_rd_reg;
    logic        hist_rd_vld_reg;
    logic [HW-1:0] hist_raddr, hist_waddr;
    logic [48:0] hist_wdata;
    logic        hist_we;
    logic [48:0] hist_q;
    assign hist_q = hist_rd_vld_reg ? hist_rd_reg : '0;

    // Running term memory {im, re} per tap.
    logic [39:0] term_mem [TDEPTH];
    logic [39:0] term_rd_reg;
    logic [TW-1:0] term_raddr, term_waddr;
    logic [39:0] term_wdata;
    logic        term_we;

    always_ff @(posedge clk)
    begin
        if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
        hist_rd_reg <= hist_mem[hist_raddr];
        if (term_we) term_mem[term_waddr] <= term_wdata;
        term_rd_reg <= term_mem[term_raddr];
    end

    // Magnitude unit. The root starts on the accepting edge, so it squares the
    // sample straight from the channel rather than the captured copy.
    logic        sq_start, sq_done;
    logic [16:0] sq_root;
    logic signed [15:0] in_re_reg, in_im_reg;
    logic signed [31:0] p_re, p_im;
    assign p_re = samples.sample_re * samples.sample_re;
    assign p_im = samples.sample_im * samples.sample_im;
    gmp_isqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start),
        .radicand(32'(p_re) + 32'(p_im)), .done(sq_done), .root(sq_root)
    );

    // Sequencer.
    localparam int INDEX_W_T = gmp_pkg::INDEX_W;
    state_t state_reg;
    logic [HW:0] sh_reg;            // history shift pointer
    logic        delayed_reg;       // phase: aligned or delayed terms
    logic [3:0]  k_reg, l_reg, m_reg;
    logic [INDEX_W_T-1:0] idx_reg;
    logic [16:0] mag_reg;
    logic signed [19:0] out_re_reg, out_im_reg;
    logic [5:0] out_idx_reg;
    logic       out_last_reg, out_vld_reg;
    logic signed [19:0] cur_re_reg, cur_im_reg;
    logic [1:0] rdph_reg;           // read phase within a term

    logic [3:0] depth, order;
    logic [3:0] kfirst;
    assign depth  = delayed_reg ? rc.lb : rc.la;
    assign order  = delayed_reg ? rc.kb : rc.ka;
    assign kfirst = delayed_reg ? 4'd1 : 4'd0;

    function automatic logic [HW-1:0] lag_sat(input logic [4:0] lag);
        begin
            if (int'(lag) > HISTORY_DEPTH - 1) return HW'(HISTORY_DEPTH - 1);
            return HW'(lag);
        end
    endfunction

    // Drops the 15 fraction bits of a product toward zero and saturates to Q4.15.
    function automatic logic signed [19:0] scale(input logic signed [38:0] p);
        logic signed [38:0] q;
        begin
            q = (p < 0) ? -((-p) >>> 15) : (p >>> 15);
            if (q > 39'(gmp_pkg::Q4_MAX)) return gmp_pkg::Q4_MAX;
            if (q < 39'(gmp_pkg::Q4_MIN)) return gmp_pkg::Q4_MIN;
            return q[19:0];
        end
    endfunction

    logic signed [38:0] prod_re_reg, prod_im_reg;
    logic last_cond;
    logic idx_end;
    assign last_cond = (l_reg + 4'd1 == depth) && (k_reg + 4'd1 == order + kfirst)
                       && (delayed_reg ? (m_reg == rc.mb) : 1'b0);
    assign idx_end = (idx_reg == INDEX_W_T'(gmp_pkg::RESULT_LIMIT - 1));

    assign samples.ready = (state_reg == S_IDLE);

    always_comb
    begin
        hist_raddr = '0; hist_waddr = '0; hist_wdata = '0; hist_we = 1'b0;
        term_raddr = TW'(l_reg); term_waddr = TW'(l_reg);
        term_wdata = {cur_im_reg, cur_re_reg}; term_we = 1'b0;
        sq_start = samples.valid && samples.ready;
        unique case (state_reg)
            S_SHIFT_RD: hist_raddr = sh_reg[HW-1:0] - HW'(1);
            S_SHIFT_WR:
            begin
                hist_we = 1'b1;
                hist_waddr = sh_reg[HW-1:0];
                hist_wdata = (sh_reg == '0) ? {sq_root, in_im_reg, in_re_reg} : hist_q;
            end
            S_TERM_RD:
                hist_raddr = (rdph_reg == 2'd0) ? lag_sat({1'b0, l_reg})
                           : lag_sat({1'b0, l_reg} + {1'b0, (delayed_reg ? m_reg : 4'd0)});
            S_TERM_WR: term_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hist_vld_reg <= '0;
            hist_rd_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            sh_reg <= '0; delayed_reg <= 1'b0;
            k_reg <= '0; l_reg <= '0; m_reg <= '0; idx_reg <= '0; rdph_reg <= '0;
        end
        else
        begin
            hist_rd_vld_reg <= hist_vld_reg[hist_raddr];
            if (hist_we) hist_vld_reg[hist_waddr] <= 1'b1;
            // The output register refills in the cycle its beat leaves.
            if (state_reg == S_TERM_WR && (!out_vld_reg || basis.ready))
                out_vld_reg <= 1'b1;
            else if (basis.valid && basis.ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (samples.valid)
                    begin
                        state_reg <= S_SQRT;
                    end
                S_SQRT:
                    if (sq_done)
                    begin
                        sh_reg <= (HW+1)'(HISTORY_DEPTH - 1);
                        state_reg <= S_SHIFT_RD;
                    end
                S_SHIFT_RD: state_reg <= S_SHIFT_WR;
                S_SHIFT_WR:
                    if (sh_reg == '0)
                    begin
                        delayed_reg <= 1'b0; k_reg <= '0; l_reg <= '0; m_reg <= 4'd1;
                        idx_reg <= '0; rdph_reg <= '0;
                        state_reg <= S_TERM_RD;
                    end
                    else
                    begin
                        sh_reg <= sh_reg - (HW+1)'(1);
                        state_reg <= S_SHIFT_RD;
                    end
                S_TERM_RD:
                begin
                    // Phase 0 reads the sample at the tap, phase 1 the envelope source,
                    // phase 2 the stored running term (each read's data arrives in the next phase).
                    rdph_reg <= rdph_reg + 2'd1;
                    if (rdph_reg == 2'd1)
                    begin
                        cur_re_reg <= 20'(signed'(hist_q[15:0]));
                        cur_im_reg <= 20'(signed'(hist_q[31:16]));
                    end
                    if (rdph_reg == 2'd2)
                    begin
                        mag_reg <= hist_q[48:32];
                    end
                    if (rdph_reg == 2'd3)
                    begin
                        if (k_reg != kfirst)
                        begin
                            cur_re_reg <= term_rd_reg[19:0];
                            cur_im_reg <= term_rd_reg[39:20];
                        end
                        state_reg <= S_TERM_MUL;
                    end
                end
                S_TERM_MUL:
                begin
                    prod_re_reg <= 39'(cur_re_reg) * $signed({1'b0, mag_reg});
                    prod_im_reg <= 39'(cur_im_reg) * $signed({1'b0, mag_reg});
                    state_reg <= (k_reg == 4'd0) ? S_TERM_WR : S_EMIT;
                end
                S_EMIT:
                begin
                    cur_re_reg <= scale(prod_re_reg);
                    cur_im_reg <= scale(prod_im_reg);
                    state_reg <= S_TERM_WR;
                end
                S_TERM_WR:
                    if (!out_vld_reg || basis.ready)
                    begin
                        out_re_reg   <= cur_re_reg;
                        out_im_reg   <= cur_im_reg;
                        out_idx_reg  <= idx_reg;
                        out_last_reg <= last_cond || idx_end;
                        idx_reg <= idx_reg + INDEX_W_T'(1);
                        if (last_cond || idx_end)
                            state_reg <= S_IDLE;
                        else
                        begin
                            state_reg <= S_TERM_RD;
                            if (l_reg + 4'd1 != depth)
                                l_reg <= l_reg + 4'd1;
                            else
                            begin
                                l_reg <= '0;
                                if (k_reg + 4'd1 != order + kfirst)
                                    k_reg <= k_reg + 4'd1;
                                else if (!delayed_reg)
                                begin
                                    delayed_reg <= 1'b1; k_reg <= 4'd1; m_reg <= 4'd1;
                                end
                                else
                                begin
                                    k_reg <= 4'd1; m_reg <= m_reg + 4'd1;
                                end
                            end
                        end
                    end
                    else
                        state_reg <= S_TERM_WR;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_re_reg <= samples.sample_re;
            in_im_reg <= samples.sample_im;
        end
    end

    assign basis.valid       = out_vld_reg;
    assign basis.basis_re    = out_re_reg;
    assign basis.basis_im    = out_im_reg;
    assign basis.basis_index = out_idx_reg;
    assign basis.last_term   = out_last_reg;

    `GMP_ASSERT_IMP(a_ready_idle, clk, rst_n, samples.ready, !sq_done)
    `GMP_ASSERT_IMP(a_no_term_write_idle, clk, rst_n, state_reg == S_IDLE, !term_we)
    `GMP_ASSERT_NEXT(a_accept_sqrt, clk, rst_n, samples.valid && samples.ready,
                     state_reg == S_SQRT)
endmodule

[tb/gmp_basis_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_basis_scoreboard
// Predicts the basis terms of each accepted sample and checks the term beats.
// ----------------------------------------------------------------------------
package gmp_basis_scoreboard_pkg;
    import gmp_pkg::*;

    typedef struct {
        logic signed [TERM_W-1:0] re;
        logic signed [TERM_W-1:0] im;
        logic [INDEX_W-1:0]       index;
        logic                     last;
    } basis_term_t;

    class gmp_basis_scoreboard;
        logic [31:0]          sample_line[HISTORY_DEPTH_DEF];
        logic [MAG_W-1:0]     envelope_line[HISTORY_DEPTH_DEF];
        logic [CFG_W-1:0]     regs[5];
        basis_term_t          pending_terms[$];
        int                   errors;
        int                   terms_checked;
        int                   cur_count;

        function new();
            foreach (sample_line[i]) begin
                sample_line[i] = '0;
                envelope_line[i] = '0;
            end
            regs[REG_ALIGNED_ORDER] = 3'd2;
            regs[REG_ALIGNED_DEPTH] = 3'd2;
            regs[REG_DELAYED_ORDER] = 3'd1;
            regs[REG_ENVELOPE_LAG]  = 3'd1;
            regs[REG_DELAYED_DEPTH] = 3'd1;
            errors = 0;
            terms_checked = 0;
            cur_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_ENVELOPE_LAG)
                regs[idx] = data & 3'd3;
            else if (idx <= REG_DELAYED_DEPTH)
                regs[idx] = data;
        endfunction

        function int clamp(int v, int maxv);
            if (v < 1) v = 1;
            if (v > maxv) v = maxv;
            return v;
        endfunction

        function longint root_floor(longint x);
            longint r;
            r = 0;
            while ((r + 1) * (r + 1) <= x) r++;
            return r;
        endfunction

        function longint scale(longint v, longint mag);
            longint p;
            p = (v * mag) / 32768;
            if (p > 524287) p = 524287;
            if (p < -524288) p = -524288;
            return p;
        endfunction

        // Terms past the limit of one sample are dropped.
        function void push_term(longint re, longint im);
            basis_term_t t;
            if (cur_count >= RESULT_LIMIT)
                return;
            t.re = re[TERM_W-1:0];
            t.im = im[TERM_W-1:0];
            t.last = 1'b0;
            t.index = 6'(cur_count);
            cur_count++;
            pending_terms.push_back(t);
        endfunction

        function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
            int ka, la, kb, mb, lb, lg;
            longint tre[4], tim[4];
            longint r, i;
            r = re;
            i = im;
            ka = clamp(regs[0], 4);
            la = clamp(regs[1], 4);
            kb = clamp(regs[2], 4);
            mb = clamp(regs[3], 3);
            lb = clamp(regs[4], 4);
            for (int h = HISTORY_DEPTH_DEF - 1; h > 0; h--) begin
                sample_line[h] = sample_line[h-1];
                envelope_line[h] = envelope_line[h-1];
            end
            sample_line[0] = {im, re};
            envelope_line[0] = MAG_W'(root_floor(r * r + i * i));
            cur_count = 0;
            for (int k = 0; k < ka; k++) begin
                for (int l = 0; l < la; l++) begin
                    if (k == 0) begin
                        tre[l] = $signed(sample_line[l][15:0]);
                        tim[l] = $signed(sample_line[l][31:16]);
                    end else begin
                        tre[l] = scale(tre[l], envelope_line[l]);
                        tim[l] = scale(tim[l], envelope_line[l]);
                    end
                    push_term(tre[l], tim[l]);
                end
            end
            for (int m = 1; m <= mb; m++) begin
                for (int l = 0; l < lb; l++) begin
                    tre[l] = $signed(sample_line[l][15:0]);
                    tim[l] = $signed(sample_line[l][31:16]);
                end
                for (int k = 1; k <= kb; k++) begin
                    for (int l = 0; l < lb; l++) begin
                        lg = (l + m > HISTORY_DEPTH_DEF - 1) ? HISTORY_DEPTH_DEF - 1 : l + m;
                        tre[l] = scale(tre[l], envelope_line[lg]);
                        tim[l] = scale(tim[l], envelope_line[lg]);
                        push_term(tre[l], tim[l]);
                    end
                end
            end
            pending_terms[$].last = 1'b1;
        endfunction

        function void check_term(basis_term_t got);
            basis_term_t want;
            if (pending_terms.size() == 0) begin
                $display("%0t: unexpected term re=%0d im=%0d index=%0d last=%0b",
                         $time, got.re, got.im, got.index, got.last);
                errors++;
                return;
            end
            want = pending_terms.pop_front();
            terms_checked++;
            if (got.re !== want.re || got.im !== want.im
                || got.index !== want.index || got.last !== want.last) begin
                $display("%0t: mismatch expected re=%0d im=%0d index=%0d last=%0b",
                         $time, want.re, want.im, want.index, want.last);
                $display("%0t:          actual   re=%0d im=%0d index=%0d last=%0b",
                         $time, got.re, got.im, got.index, got.last);
                errors++;
            end
        endfunction
    endclass
endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives samples through the basis generator under several register settings
// and compares every term beat against an in-testbench prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import gmp_pkg::*;
    import gmp_basis_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    // Worst settling time after the last term: history shift plus root plus slack.
    localparam int DRAIN_CYCLES = 300;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    gmp_sample_if samples();
    gmp_basis_if  basis();

    gmp_basis_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples.sink),
        .basis    (basis.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    gmp_basis_scoreboard board = new();

    // The receiver stalls on a random pattern unless sink_steady holds it ready; long_hold forces a
    // long stall so the block fills up and pushes back on the sample side.
    bit long_hold;
    bit sink_steady;
    int cycle_count;
    int samples_sent;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a hung block must still end the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Term beats are sampled at the rising edge and go straight to the checker.
    always @(posedge clk)
    begin
        basis_term_t t;
        if (rst_n && basis.valid && basis.ready)
        begin
            t.re = basis.basis_re;
            t.im = basis.basis_im;
            t.index = basis.basis_index;
            t.last = basis.last_term;
            board.check_term(t);
        end
    end

    // Receiver: ready changes on the falling edge only.
    always @(negedge clk)
    begin
        if (long_hold)
            basis.ready <= 1'b0;
        else if (sink_steady)
            basis.ready <= 1'b1;
        else
            basis.ready <= ($urandom_range(0, 3) != 0);
    end

    // Long hold-off, counted in cycles in its own process.
    task automatic hold_receiver(int cycles);
        long_hold = 1'b1;
        repeat (cycles) @(negedge clk);
        long_hold = 1'b0;
    endtask

    // One sample beat: present at the falling edge, wait for the handshake,
    // and record the sample in the predictor once it is taken.
    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
        samples.valid <= 1'b1;
        samples.sample_re <= re;
        samples.sample_im <= im;
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
        board.note_sample(re, im);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        samples.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Waits for every predicted term, then lets the block settle.
    task automatic drain();
        samples.valid <= 1'b0;
        while (board.pending_terms.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, data);
    endtask

    task automatic set_all(int ka, int la, int kb, int mb, int lb);
        write_reg(REG_ALIGNED_ORDER, CFG_W'(ka));
        write_reg(REG_ALIGNED_DEPTH, CFG_W'(la));
        write_reg(REG_DELAYED_ORDER, CFG_W'(kb));
        write_reg(REG_ENVELOPE_LAG, CFG_W'(mb));
        write_reg(REG_DELAYED_DEPTH, CFG_W'(lb));
    endtask

    // Random bursts of samples; most are full scale, some sit near zero.
    task automatic random_phase(int count);
        int left;
        int burst;
        logic signed [15:0] re, im;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 6);
            for (int j = 0; j < burst && left > 0; j++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    re = 16'($signed($urandom_range(0, 64)) - 32);
                    im = 16'($signed($urandom_range(0, 64)) - 32);
                end
                else
                begin
                    re = 16'($urandom);
                    im = 16'($urandom);
                end
                send_sample(re, im);
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 40));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.sample_re = '0;
        samples.sample_im = '0;
        basis.ready = 1'b0;
        long_hold = 1'b0;
        sink_steady = 1'b0;
        cycle_count = 0;
        samples_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge clk);

        // Directed part at reset defaults: extremes of both fields, zero,
        // and the deepest negative corner that drives the envelope highest.
        sink_steady = 1'b1;
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sh8000, -16'sh8000);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(-16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, -16'sh8000);
        send_sample(16'sh5555, -16'sh2AAB);
        drain();

        // Largest setting: 64 terms per sample, lags reaching six entries back in the line.
        set_all(4, 4, 4, 3, 4);
        for (int j = 0; j < 6; j++)
            send_sample(-16'sh8000 + 16'(j * 13107), 16'sh7FFF - 16'(j * 13107));
        drain();

        // Zero registers read as one; values past the maximum saturate.
        set_all(0, 0, 0, 0, 0);
        send_sample(16'sh7FFF, -16'sh8000);
        send_sample(16'sh1234, 16'shEDCB);
        drain();
        set_all(7, 7, 7, 3, 7);
        send_sample(-16'sh8000, -16'sh8000);
        send_sample(16'sh4000, 16'sh4000);
        drain();

        // Unknown register index: the write must be ignored.
        write_reg(3'd5, 3'd0);
        write_reg(3'd7, 3'd0);
        send_sample(16'sh7FFF, 16'sh0001);
        drain();

        // Random phases through a spread of settings, the smallest included.
        sink_steady = 1'b0;
        set_all(1, 1, 1, 1, 1);
        random_phase(25);
        drain();

        // Receiver held off while the sender keeps offering samples.
        set_all(2, 3, 2, 2, 2);
        fork
            hold_receiver(600);
            random_phase(10);
        join
        drain();

        set_all($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                $urandom_range(1, 3), $urandom_range(1, 4));
        random_phase(30);
        drain();

        set_all(4, 4, 4, 3, 4);
        random_phase(20);
        drain();

        $display("Sent %0d samples across default, minimum, maximum and saturated settings;",
                 samples_sent);
        $display("checked %0d basis terms under random stalls and a long receiver hold.",
                 board.terms_checked);
        if (board.errors == 0 && board.pending_terms.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
